FILE: src/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define FFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ffa_pkg.sv
package ffa_pkg;

    localparam int unsigned MAX_EXTENTS_DEF = 64;
    localparam logic [31:0] DATA_START_RST  = 32'd4096;
    localparam logic [31:0] REGION_SIZE_RST = 32'd1048576;

    // Configuration register indexes.
    localparam logic CFG_DATA_START  = 1'b0;
    localparam logic CFG_REGION_SIZE = 1'b1;

    // Request type codes.
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_ALLOC  = 1'b1;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_ALLOC,
        OP_REFUSE
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] start;
        logic [31:0] len;
    } op_t;

    typedef struct packed {
        logic [31:0] data_start;
        logic [31:0] region_size;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_NXT_RD,
        ST_NXT_CMP,
        ST_PUT_RD,
        ST_PUT_CMP,
        ST_PUT_DECIDE,
        ST_SH_RD,
        ST_SH_WR
    } back_state_t;

endpackage

FILE: src/first_fit_extent_allocator.sv
// First-fit extent allocator. A request is taken at a rising edge where
// start is high and busy is low; up to two requests wait in a queue while
// the engine works, and busy rises only when that queue is full. Every
// request gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall it, so it must take it in that cycle. The
// extent table has one read and one write port and is read one entry at
// a time. A record that inserts scans to the insert position and then
// shifts the entries behind it up by one; a record that overwrites ends
// as soon as its entry is found. An allocate tries data_start and then
// the end of each held extent in table order as candidates; each is
// checked against the region size and then the table up to the first
// overlap, and the first that fits is then recorded.
// Configuration is written through cfg_valid, which is always ready; write
// only while no request is pending.
module first_fit_extent_allocator #(
    parameter int unsigned MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] extent_start,
    input  logic [31:0] extent_length,
    output logic        done,
    output logic        granted,
    output logic [31:0] placed_at,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ffa_pkg::*;

`include "assert_macros.svh"

    logic [31:0] data_start_reg;
    logic [31:0] region_size_reg;
    cfg_t        cfg;
    logic        head_valid;
    op_t         head;
    logic        pop;

    // Configuration beats are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg.data_start  = data_start_reg;
    assign cfg.region_size = region_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg  <= DATA_START_RST;
            region_size_reg <= REGION_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DATA_START:  data_start_reg  <= cfg_data;
                CFG_REGION_SIZE: region_size_reg <= cfg_data;
                default:         data_start_reg  <= data_start_reg;
            endcase
        end
    end

    // The front classifies requests and queues them for the engine.
    ffa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .extent_start  (extent_start),
        .extent_length (extent_length),
        .pop           (pop),
        .busy          (busy),
        .head_valid    (head_valid),
        .head          (head)
    );

    // The back holds the sorted extent table and runs the searches.
    ffa_back #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .granted    (granted),
        .placed_at  (placed_at)
    );

    // A refused request always reports a zero placement.
    `FFA_ASSERT(a_refuse_zero, (done && !granted) |-> (placed_at == 32'd0), "nonzero refusal")
    // An accepted request is waiting in the queue on the next cycle.
    `FFA_ASSERT(a_accept_queued, (start && !busy) |=> head_valid, "request not queued")
    // The engine only pops when something is queued.
    `FFA_ASSERT(a_pop_valid, pop |-> head_valid, "pop from empty queue")

endmodule

FILE: src/ffa_front.sv
module ffa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          req_type,
    input  logic [31:0]   extent_start,
    input  logic [31:0]   extent_length,
    input  logic          pop,
    output logic          busy,
    output logic          head_valid,
    output ffa_pkg::op_t  head
);
    import ffa_pkg::*;

    // Two-entry queue of classified requests.
    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       do_pop;
    op_t        incoming;

    always_comb
    begin
        incoming.start = extent_start;
        incoming.len   = extent_length;
        if (req_type == REQ_RECORD)
            incoming.kind = OP_RECORD;
        else if (extent_length == 32'd0)
            incoming.kind = OP_REFUSE;
        else
            incoming.kind = OP_ALLOC;
    end

    assign busy       = (fill_reg == 2'd2);
    assign push       = start && !busy;
    assign head_valid = (fill_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= incoming;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: src/ffa_back.sv
module ffa_back #(
    parameter int unsigned MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffa_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  ffa_pkg::op_t  head,
    output logic          pop,
    output logic          done,
    output logic          granted,
    output logic [31:0]   placed_at
);
    import ffa_pkg::*;

    localparam int unsigned AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

    // Entry: start in the upper half, length in the lower half.
    logic [63:0] mem [MAX_EXTENTS];
    logic [63:0] rd_q;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;

    back_state_t state_reg;
    back_state_t state_next;
    op_t         op_reg;
    op_t         op_next;
    logic [32:0] cand_reg;
    logic [32:0] cand_next;
    logic [CW-1:0] cidx_reg;
    logic [CW-1:0] cidx_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          done_next;
    logic          granted_reg;
    logic          granted_next;
    logic [31:0]   placed_reg;
    logic [31:0]   placed_next;

    logic [31:0] q_start;
    logic [31:0] q_len;
    logic [32:0] q_end;
    logic [33:0] cand_end;
    logic        bound_fail;
    logic        overlap;
    logic        last_idx;
    logic        no_more_cand;
    logic        full;
    logic        empty;

    assign q_start      = rd_q[63:32];
    assign q_len        = rd_q[31:0];
    assign q_end        = {1'b0, q_start} + {1'b0, q_len};
    assign cand_end     = {1'b0, cand_reg} + {2'b00, op_reg.len};
    assign bound_fail   = cand_end > {2'b00, cfg.region_size};
    // Half-open interval test; an empty extent covers no bytes.
    assign overlap      = (q_len != 32'd0) && (cand_reg < q_end) &&
                          ({2'b00, q_start} < cand_end);
    assign last_idx     = (idx_reg == count_reg - CW'(1));
    assign no_more_cand = (cidx_reg == count_reg);
    assign full         = (count_reg == CW'(MAX_EXTENTS));
    assign empty        = (count_reg == CW'(0));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind)
                        OP_RECORD: state_next = empty ? ST_PUT_DECIDE : ST_PUT_RD;
                        OP_ALLOC:  state_next = ST_BOUND;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BOUND:
            begin
                if (bound_fail)
                    state_next = no_more_cand ? ST_IDLE : ST_NXT_RD;
                else if (empty)
                    state_next = ST_PUT_DECIDE;
                else
                    state_next = ST_CHK_RD;
            end
            ST_CHK_RD:  state_next = ST_CHK_CMP;
            ST_CHK_CMP:
            begin
                if (overlap)
                    state_next = no_more_cand ? ST_IDLE : ST_NXT_RD;
                else if (last_idx)
                    state_next = ST_PUT_RD;
                else
                    state_next = ST_CHK_RD;
            end
            ST_NXT_RD:  state_next = ST_NXT_CMP;
            ST_NXT_CMP: state_next = ST_BOUND;
            ST_PUT_RD:  state_next = ST_PUT_CMP;
            ST_PUT_CMP:
            begin
                if (q_start == op_reg.start)
                    state_next = ST_IDLE;
                else if (q_start > op_reg.start || last_idx)
                    state_next = ST_PUT_DECIDE;
                else
                    state_next = ST_PUT_RD;
            end
            ST_PUT_DECIDE: state_next = full ? ST_IDLE : ST_SH_RD;
            ST_SH_RD:   state_next = (idx_reg == pos_reg) ? ST_IDLE : ST_SH_WR;
            ST_SH_WR:   state_next = ST_SH_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        op_next      = op_reg;
        cand_next    = cand_reg;
        cidx_next    = cidx_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        granted_next = 1'b0;
        placed_next  = 32'd0;
        pop          = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = {op_reg.start, op_reg.len};
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    op_next   = head;
                    idx_next  = CW'(0);
                    pos_next  = CW'(0);
                    cidx_next = CW'(0);
                    cand_next = {1'b0, cfg.data_start};
                    if (head.kind == OP_REFUSE)
                        done_next = 1'b1;
                end
            end
            ST_BOUND:
            begin
                idx_next = CW'(0);
                pos_next = CW'(0);
                if (bound_fail)
                begin
                    if (no_more_cand)
                        done_next = 1'b1;
                end
                else
                    op_next.start = cand_reg[31:0];
            end
            ST_CHK_CMP:
            begin
                if (overlap)
                begin
                    if (no_more_cand)
                        done_next = 1'b1;
                end
                else if (last_idx)
                    idx_next = CW'(0);
                else
                    idx_next = idx_reg + CW'(1);
            end
            ST_NXT_RD:  rd_addr = cidx_reg[AW-1:0];
            ST_NXT_CMP:
            begin
                cand_next = q_end;
                cidx_next = cidx_reg + CW'(1);
            end
            ST_PUT_CMP:
            begin
                if (q_start == op_reg.start)
                begin
                    wr_en        = 1'b1;
                    done_next    = 1'b1;
                    granted_next = 1'b1;
                    placed_next  = op_reg.start;
                end
                else if (q_start > op_reg.start)
                    pos_next = idx_reg;
                else if (last_idx)
                    pos_next = count_reg;
                else
                    idx_next = idx_reg + CW'(1);
            end
            ST_PUT_DECIDE:
            begin
                idx_next = count_reg;
                if (full)
                    done_next = 1'b1;
            end
            ST_SH_RD:
            begin
                rd_addr = AW'(idx_reg - CW'(1));
                if (idx_reg == pos_reg)
                begin
                    wr_en        = 1'b1;
                    count_next   = count_reg + CW'(1);
                    done_next    = 1'b1;
                    granted_next = 1'b1;
                    placed_next  = op_reg.start;
                end
            end
            ST_SH_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_q;
                idx_next = idx_reg - CW'(1);
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cand_reg   <= cand_next;
        cidx_reg   <= cidx_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        granted_reg <= granted_next;
        placed_reg <= placed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CW'(0);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign done      = done_reg;
    assign granted   = granted_reg;
    assign placed_at = placed_reg;

endmodule
